// ===== src/lmc_pkg.sv =====
// ----------------------------------------------------------------------------
// lmc_pkg
// Shared types and constants for the LED mode cycler with fade.
// ----------------------------------------------------------------------------
`default_nettype none

package lmc_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned IvW     = 16;
  localparam int unsigned DutyW   = 8;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned BeepW   = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  // operating modes
  localparam logic [ModeW-1:0] MODE_OFF   = 2'd0;
  localparam logic [ModeW-1:0] MODE_BLINK = 2'd1;
  localparam logic [ModeW-1:0] MODE_BOTH  = 2'd2;
  localparam logic [ModeW-1:0] MODE_FADE  = 2'd3;

  // beep event codes
  localparam logic [BeepW-1:0] BEEP_NONE  = 2'd0;
  localparam logic [BeepW-1:0] BEEP_MODE  = 2'd1;
  localparam logic [BeepW-1:0] BEEP_RESET = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BLINK_IV  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FADE_IV   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_FADE_STEP = 2'd3;

  // configuration reset values
  localparam logic [IvW-1:0]   DEBOUNCE_RST  = 16'd200;
  localparam logic [IvW-1:0]   BLINK_IV_RST  = 16'd400;
  localparam logic [IvW-1:0]   FADE_IV_RST   = 16'd30;
  localparam logic [DutyW-1:0] FADE_STEP_RST = 8'd4;

  localparam logic [DutyW-1:0] DUTY_MAX = 8'd255;

  typedef struct packed {
    logic [IvW-1:0]   press_gap;
    logic [IvW-1:0]   blink_interval_ms;
    logic [IvW-1:0]   fade_interval_ms;
    logic [DutyW-1:0] duty_step;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             mode_button;
    logic             reset_button;
  } sample_t;

  typedef struct packed {
    logic [ModeW-1:0] mode_now;
    logic             led_a_level;
    logic             led_b_level;
    logic             indicator_level;
    logic             pwm_active;
    logic [DutyW-1:0] duty;
    logic [BeepW-1:0] beep_event;
  } result_t;

endpackage

`default_nettype wire

// ===== src/lmc_if.sv =====
// ----------------------------------------------------------------------------
// lmc_if
// Valid/ready channels: sample input, result output and configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmc_in_if;
  logic                       valid;
  logic                       ready;
  logic [lmc_pkg::TimeW-1:0]  now_ms;
  logic                       mode_button;
  logic                       reset_button;

  modport source (output valid, now_ms, mode_button, reset_button, input ready);
  modport sink   (input valid, now_ms, mode_button, reset_button, output ready);
endinterface

interface lmc_out_if;
  logic                       valid;
  logic                       ready;
  logic [lmc_pkg::ModeW-1:0]  mode_now;
  logic                       led_a_level;
  logic                       led_b_level;
  logic                       indicator_level;
  logic                       pwm_active;
  logic [lmc_pkg::DutyW-1:0]  duty;
  logic [lmc_pkg::BeepW-1:0]  beep_event;

  modport source (output valid, mode_now, led_a_level, led_b_level, indicator_level,
                  pwm_active, duty, beep_event, input ready);
  modport sink   (input valid, mode_now, led_a_level, led_b_level, indicator_level,
                  pwm_active, duty, beep_event, output ready);
endinterface

interface lmc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lmc_pkg::CfgIdxW-1:0]  index;
  logic [lmc_pkg::CfgDatW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/lmc_cfg.sv =====
// ----------------------------------------------------------------------------
// lmc_cfg
// Configuration register file, written through the cfg channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lmc_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_en_i,
  input  wire logic [lmc_pkg::CfgIdxW-1:0] wr_idx_i,
  input  wire logic [lmc_pkg::CfgDatW-1:0] wr_data_i,
  output lmc_pkg::cfg_t      cfg_o
);

  lmc_pkg::cfg_t cfg_q;
  lmc_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_idx_i)
        lmc_pkg::CFG_DEBOUNCE:  cfg_d.press_gap         = wr_data_i;
        lmc_pkg::CFG_BLINK_IV:  cfg_d.blink_interval_ms = wr_data_i;
        lmc_pkg::CFG_FADE_IV:   cfg_d.fade_interval_ms  = wr_data_i;
        lmc_pkg::CFG_FADE_STEP: cfg_d.duty_step         = wr_data_i[lmc_pkg::DutyW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_gap         <= lmc_pkg::DEBOUNCE_RST;
      cfg_q.blink_interval_ms <= lmc_pkg::BLINK_IV_RST;
      cfg_q.fade_interval_ms  <= lmc_pkg::FADE_IV_RST;
      cfg_q.duty_step         <= lmc_pkg::FADE_STEP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== src/lmc_engine.sv =====
// ----------------------------------------------------------------------------
// lmc_engine
// Mode state and per-sample update: debounce, mode entry, blink and fade.
// ----------------------------------------------------------------------------
`default_nettype none

module lmc_engine (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire lmc_pkg::cfg_t   cfg_i,
  input  wire lmc_pkg::sample_t smp_i,
  output lmc_pkg::result_t     res_o
);

  logic [lmc_pkg::ModeW-1:0] mode_q, mode_d;
  logic [lmc_pkg::TimeW-1:0] press_q, press_d;
  logic [lmc_pkg::TimeW-1:0] stept_q, stept_d;
  logic [lmc_pkg::DutyW-1:0] level_q, level_d;
  logic                      rising_q, rising_d;
  logic                      mb_q, rb_q;
  logic                      led_a_q, led_a_d;
  logic                      led_b_q, led_b_d;
  logic                      ind_q, ind_d;

  logic [lmc_pkg::TimeW-1:0] el_mode, el_rst, el_step;
  logic                      mode_hit, rst_hit;
  logic [lmc_pkg::BeepW-1:0] beep;
  logic signed [lmc_pkg::DutyW+1:0] fv;

  always_comb begin
    mode_d   = mode_q;
    press_d  = press_q;
    stept_d  = stept_q;
    level_d  = level_q;
    rising_d = rising_q;
    led_a_d  = led_a_q;
    led_b_d  = led_b_q;
    ind_d    = ind_q;
    beep     = lmc_pkg::BEEP_NONE;
    fv       = '0;

    // mode button: debounced falling edge
    el_mode  = smp_i.now_ms - press_q;
    mode_hit = !smp_i.mode_button && mb_q &&
               (el_mode > {16'd0, cfg_i.press_gap});
    if (mode_hit) begin
      press_d = smp_i.now_ms;
      mode_d  = mode_q + 2'd1;
      beep    = lmc_pkg::BEEP_MODE;
    end

    // reset button, checked against the press time just updated
    el_rst  = smp_i.now_ms - press_d;
    rst_hit = !smp_i.reset_button && rb_q &&
              (el_rst > {16'd0, cfg_i.press_gap});
    if (rst_hit) begin
      press_d = smp_i.now_ms;
      mode_d  = lmc_pkg::MODE_OFF;
      beep    = lmc_pkg::BEEP_RESET;
    end

    // mode entry
    if (mode_hit || rst_hit) begin
      led_a_d = 1'b0;
      led_b_d = 1'b0;
      ind_d   = 1'b0;
      unique case (mode_d)
        lmc_pkg::MODE_BLINK: begin
          led_a_d = 1'b1;
          ind_d   = 1'b1;
          stept_d = smp_i.now_ms;
        end
        lmc_pkg::MODE_BOTH: begin
          led_a_d = 1'b1;
          led_b_d = 1'b1;
        end
        lmc_pkg::MODE_FADE: begin
          level_d  = '0;
          rising_d = 1'b1;
          ind_d    = 1'b1;
        end
        lmc_pkg::MODE_OFF: ;
      endcase
    end

    el_step = smp_i.now_ms - stept_d;
    if (mode_d == lmc_pkg::MODE_BLINK) begin
      if (el_step >= {16'd0, cfg_i.blink_interval_ms}) begin
        stept_d = smp_i.now_ms;
        led_a_d = !led_a_d;
        led_b_d = !led_b_d;
      end
    end else if (mode_d == lmc_pkg::MODE_FADE) begin
      if (el_step >= {16'd0, cfg_i.fade_interval_ms}) begin
        stept_d = smp_i.now_ms;
        if (rising_d) begin
          fv = $signed({2'b00, level_d}) + $signed({2'b00, cfg_i.duty_step});
        end else begin
          fv = $signed({2'b00, level_d}) - $signed({2'b00, cfg_i.duty_step});
        end
        // clamp to the duty range and turn at the ends
        if (fv >= $signed({2'b00, lmc_pkg::DUTY_MAX})) begin
          level_d  = lmc_pkg::DUTY_MAX;
          rising_d = 1'b0;
        end else if (fv <= 10'sd0) begin
          level_d  = '0;
          rising_d = 1'b1;
        end else begin
          level_d  = fv[lmc_pkg::DutyW-1:0];
        end
      end
    end

    res_o.mode_now        = mode_d;
    res_o.led_a_level     = led_a_d;
    res_o.led_b_level     = led_b_d;
    res_o.indicator_level = ind_d;
    res_o.pwm_active      = (mode_d == lmc_pkg::MODE_FADE);
    res_o.duty            = (mode_d == lmc_pkg::MODE_FADE) ? level_d : '0;
    res_o.beep_event      = beep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= lmc_pkg::MODE_OFF;
      press_q  <= '0;
      stept_q  <= '0;
      level_q  <= '0;
      rising_q <= 1'b1;
      mb_q     <= 1'b1;
      rb_q     <= 1'b1;
      led_a_q  <= 1'b0;
      led_b_q  <= 1'b0;
      ind_q    <= 1'b0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      press_q  <= press_d;
      stept_q  <= stept_d;
      level_q  <= level_d;
      rising_q <= rising_d;
      mb_q     <= smp_i.mode_button;
      rb_q     <= smp_i.reset_button;
      led_a_q  <= led_a_d;
      led_b_q  <= led_b_d;
      ind_q    <= ind_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/led_mode_cycler_with_fade.sv =====
// ----------------------------------------------------------------------------
// led_mode_cycler_with_fade
// Four-mode LED controller with debounced buttons, blink and PWM fade.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                       handshake
//  in_i     in   now_ms, mode_button, reset_button             valid/ready
//  out_o    out  mode_now, led_a/b_level, indicator_level,     valid/ready
//                pwm_active, duty, beep_event
//  cfg_i    in   index (0..3), data                            valid/ready
//
//  One sample per clock sustained while out_o is not stalled; a result is
//  valid on out_o after its sample is taken (sample, then result register).
//  The mode/fade update is one combinational pass between those registers.
//  A stalled result holds the pipeline; the sample register fills only if empty.
//  Reset restores the default intervals and clears all mode state.
// ----------------------------------------------------------------------------
`default_nettype none

module led_mode_cycler_with_fade (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lmc_in_if.sink      in_i,
  lmc_out_if.source   out_o,
  lmc_cfg_if.sink     cfg_i
);

  lmc_pkg::cfg_t    cfg;
  lmc_pkg::sample_t smp_q;
  lmc_pkg::result_t res_d, res_q;
  logic             smp_vld_q;
  logic             out_vld_q;
  logic             advance;

  assign cfg_i.ready = 1'b1;

  lmc_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  assign advance    = smp_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !smp_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        smp_vld_q <= in_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      smp_q.now_ms       <= in_i.now_ms;
      smp_q.mode_button  <= in_i.mode_button;
      smp_q.reset_button <= in_i.reset_button;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  lmc_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .cfg_i  (cfg),
    .smp_i  (smp_q),
    .res_o  (res_d)
  );

  assign out_o.valid           = out_vld_q;
  assign out_o.mode_now        = res_q.mode_now;
  assign out_o.led_a_level     = res_q.led_a_level;
  assign out_o.led_b_level     = res_q.led_b_level;
  assign out_o.indicator_level = res_q.indicator_level;
  assign out_o.pwm_active      = res_q.pwm_active;
  assign out_o.duty            = res_q.duty;
  assign out_o.beep_event      = res_q.beep_event;

`ifndef SYNTHESIS
  a_fade_leds_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.pwm_active |-> !out_o.led_a_level && !out_o.led_b_level)
    else $error("LED levels high while fading");

  a_reset_beep_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.beep_event == lmc_pkg::BEEP_RESET
      |-> out_o.mode_now == lmc_pkg::MODE_OFF)
    else $error("reset beep without mode off");

  a_duty_only_fade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.duty != '0 |-> out_o.pwm_active)
    else $error("duty outside fade mode");

  a_no_result_without_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q && !smp_vld_q |=> !out_vld_q)
    else $error("result raised with no sample pending");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED mode cycler with fade. Timestamped button
// samples go in over the input channel. A behavioural model of the mode, blink
// and fade logic predicts each result, and every result from the output
// channel is compared field by field. Directed cases come first, then random
// button traffic under several register settings, with bursts of stalls on
// both channels.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TimeW   = lmc_pkg::TimeW;
  localparam int unsigned DutyW   = lmc_pkg::DutyW;
  localparam int unsigned ModeW   = lmc_pkg::ModeW;
  localparam int unsigned BeepW   = lmc_pkg::BeepW;
  localparam int unsigned CfgIdxW = lmc_pkg::CfgIdxW;
  localparam int unsigned CfgDatW = lmc_pkg::CfgDatW;

  logic clk_i;
  logic rst_ni;

  lmc_in_if  in_ch ();
  lmc_out_if out_ch ();
  lmc_cfg_if cfg_ch ();

  led_mode_cycler_with_fade dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // predicted block state
  lmc_pkg::cfg_t    m_cfg;
  logic [ModeW-1:0] m_mode;
  logic [TimeW-1:0] m_press_t;
  logic [TimeW-1:0] m_step_t;
  logic             m_prev_mb;
  logic             m_prev_rb;
  logic [DutyW-1:0] m_level;
  logic             m_rising;
  logic             m_led_a;
  logic             m_led_b;
  logic             m_ind;

  lmc_pkg::result_t expected_results[$];
  int unsigned      mismatch_count;
  bit               idling_on;
  bit               tail_part;
  logic [TimeW-1:0] clock_ms;
  int               mode_hold;
  int               reset_hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------
  function automatic void enter_mode_state(input logic [TimeW-1:0] now);
    m_led_a = 1'b0;
    m_led_b = 1'b0;
    m_ind   = 1'b0;
    case (m_mode)
      lmc_pkg::MODE_BLINK: begin
        m_led_a  = 1'b1;
        m_ind    = 1'b1;
        m_step_t = now;
      end
      lmc_pkg::MODE_BOTH: begin
        m_led_a = 1'b1;
        m_led_b = 1'b1;
      end
      lmc_pkg::MODE_FADE: begin
        m_level  = '0;
        m_rising = 1'b1;
        m_ind    = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic lmc_pkg::result_t next_led_outputs(input lmc_pkg::sample_t s);
    lmc_pkg::result_t res;
    logic [BeepW-1:0] beep;
    int               lvl;
    beep = lmc_pkg::BEEP_NONE;
    if (!s.mode_button && m_prev_mb &&
        (s.now_ms - m_press_t) > TimeW'(m_cfg.press_gap)) begin
      m_press_t = s.now_ms;
      m_mode    = m_mode + 1'b1;
      enter_mode_state(s.now_ms);
      beep = lmc_pkg::BEEP_MODE;
    end
    m_prev_mb = s.mode_button;
    // reset sees the press time the mode button may just have moved
    if (!s.reset_button && m_prev_rb &&
        (s.now_ms - m_press_t) > TimeW'(m_cfg.press_gap)) begin
      m_press_t = s.now_ms;
      m_mode    = lmc_pkg::MODE_OFF;
      enter_mode_state(s.now_ms);
      beep = lmc_pkg::BEEP_RESET;
    end
    m_prev_rb = s.reset_button;
    if (m_mode == lmc_pkg::MODE_BLINK) begin
      if ((s.now_ms - m_step_t) >= TimeW'(m_cfg.blink_interval_ms)) begin
        m_step_t = s.now_ms;
        m_led_a  = ~m_led_a;
        m_led_b  = ~m_led_b;
      end
    end else if (m_mode == lmc_pkg::MODE_FADE) begin
      if ((s.now_ms - m_step_t) >= TimeW'(m_cfg.fade_interval_ms)) begin
        m_step_t = s.now_ms;
        lvl = int'(m_level);
        if (m_rising) lvl += int'(m_cfg.duty_step);
        else lvl -= int'(m_cfg.duty_step);
        if (lvl >= int'(lmc_pkg::DUTY_MAX)) begin
          lvl      = int'(lmc_pkg::DUTY_MAX);
          m_rising = 1'b0;
        end
        if (lvl <= 0) begin
          lvl      = 0;
          m_rising = 1'b1;
        end
        m_level = DutyW'(lvl);
      end
    end
    res.mode_now        = m_mode;
    res.led_a_level     = m_led_a;
    res.led_b_level     = m_led_b;
    res.indicator_level = m_ind;
    res.pwm_active      = (m_mode == lmc_pkg::MODE_FADE);
    res.duty            = (m_mode == lmc_pkg::MODE_FADE) ? m_level : '0;
    res.beep_event      = beep;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 40) begin
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) stall--;
      else if (idling_on && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 12);
      out_ch.ready <= (stall == 0);
    end
  end

  always @(posedge clk_i) begin
    lmc_pkg::result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending, mode_now", int'(out_ch.mode_now), -1);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.mode_now !== want.mode_now)
          report_mismatch("mode_now", int'(out_ch.mode_now), int'(want.mode_now));
        if (out_ch.led_a_level !== want.led_a_level)
          report_mismatch("led_a_level", int'(out_ch.led_a_level), int'(want.led_a_level));
        if (out_ch.led_b_level !== want.led_b_level)
          report_mismatch("led_b_level", int'(out_ch.led_b_level), int'(want.led_b_level));
        if (out_ch.indicator_level !== want.indicator_level)
          report_mismatch("indicator_level", int'(out_ch.indicator_level),
                          int'(want.indicator_level));
        if (out_ch.pwm_active !== want.pwm_active)
          report_mismatch("pwm_active", int'(out_ch.pwm_active), int'(want.pwm_active));
        if (out_ch.duty !== want.duty)
          report_mismatch("duty", int'(out_ch.duty), int'(want.duty));
        if (out_ch.beep_event !== want.beep_event)
          report_mismatch("beep_event", int'(out_ch.beep_event), int'(want.beep_event));
      end
    end
  end

  // --------------------------------------------------------------------------
  // channel drivers
  // --------------------------------------------------------------------------
  task automatic send_sample(input logic [TimeW-1:0] now, input logic mb, input logic rb);
    lmc_pkg::sample_t s;
    int               gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 12);
    repeat (gap) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    s = '{now, mb, rb};
    clock_ms = now;
    @(negedge clk_i);
    in_ch.valid        <= 1'b1;
    in_ch.now_ms       <= now;
    in_ch.mode_button  <= mb;
    in_ch.reset_button <= rb;
    forever begin
      @(posedge clk_i);
      if (in_ch.ready) break;
    end
    expected_results.push_back(next_led_outputs(s));
  endtask

  task automatic wait_results_drained();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    wait_results_drained();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    forever begin
      @(posedge clk_i);
      if (cfg_ch.ready) break;
    end
    case (idx)
      lmc_pkg::CFG_DEBOUNCE:  m_cfg.press_gap         = data;
      lmc_pkg::CFG_BLINK_IV:  m_cfg.blink_interval_ms = data;
      lmc_pkg::CFG_FADE_IV:   m_cfg.fade_interval_ms  = data;
      lmc_pkg::CFG_FADE_STEP: m_cfg.duty_step         = data[DutyW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_config(input int deb, input int blink, input int fiv, input int step);
    write_reg(lmc_pkg::CFG_DEBOUNCE, CfgDatW'(deb));
    write_reg(lmc_pkg::CFG_BLINK_IV, CfgDatW'(blink));
    write_reg(lmc_pkg::CFG_FADE_IV, CfgDatW'(fiv));
    write_reg(lmc_pkg::CFG_FADE_STEP, CfgDatW'(step));
  endtask

  // press/release traffic with random spacing; a little of it is plain noise
  task automatic run_button_traffic(input int count, input int max_dt, input int press_odds);
    logic [TimeW-1:0] dt;
    logic             mb;
    logic             rb;
    int               pick;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) idling_on = !tail_part && $urandom_range(0, 2) != 0;
      pick = $urandom_range(0, 19);
      if (pick < 13) dt = $urandom_range(0, max_dt);
      else if (pick < 15) dt = '0;
      else if (pick < 17) dt = $urandom_range(0, 3 * max_dt);
      else if (pick == 17) dt = $urandom;
      else dt = TimeW'(m_cfg.press_gap) + $urandom_range(0, 2);
      if ($urandom_range(0, 15) == 0) begin
        mb = 1'($urandom_range(0, 1));
        rb = 1'($urandom_range(0, 1));
      end else begin
        if (mode_hold == 0 && $urandom_range(1, press_odds) == 1)
          mode_hold = $urandom_range(1, 4);
        if (reset_hold == 0 && $urandom_range(1, 4 * press_odds) == 1)
          reset_hold = $urandom_range(1, 3);
        mb = (mode_hold == 0);
        rb = (reset_hold == 0);
        if (mode_hold > 0) mode_hold--;
        if (reset_hold > 0) reset_hold--;
      end
      send_sample(clock_ms + dt, mb, rb);
      if (!tail_part && $urandom_range(0, 199) == 0) wait_results_drained();
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_mode_cycle();
    send_sample(32'd0, 1'b1, 1'b1);
    send_sample(32'd1000, 1'b0, 1'b1);  // into blink
    send_sample(32'd1100, 1'b1, 1'b1);
    send_sample(32'd1500, 1'b1, 1'b1);  // blink toggle
    send_sample(32'd2000, 1'b0, 1'b1);  // both on
    send_sample(32'd2050, 1'b1, 1'b1);
    send_sample(32'd3000, 1'b0, 1'b1);  // fade
    send_sample(32'd3040, 1'b1, 1'b1);
    send_sample(32'd4000, 1'b0, 1'b1);  // back to off
  endtask

  task automatic test_buttons_together();
    send_sample(32'd4001, 1'b1, 1'b1);
    send_sample(32'd5000, 1'b0, 1'b0);  // mode wins, reset falls inside debounce
    send_sample(32'd5001, 1'b1, 1'b1);
    wait_results_drained();
    send_sample(32'd5300, 1'b1, 1'b0);
    send_sample(32'd5301, 1'b1, 1'b1);
    send_sample(32'd5600, 1'b1, 1'b0);  // reset while already off
    send_sample(32'd5601, 1'b1, 1'b1);
  endtask

  task automatic test_debounce_edge();
    send_sample(32'd5800, 1'b0, 1'b1);  // elapsed equals debounce: ignored
    send_sample(32'd5801, 1'b1, 1'b1);
    send_sample(32'd5802, 1'b0, 1'b1);
    send_sample(32'd5803, 1'b1, 1'b1);
  endtask

  task automatic test_time_wrap();
    send_sample(32'hFFFF_FFFF, 1'b0, 1'b1);
    send_sample(32'd0, 1'b1, 1'b1);
    send_sample(32'd300, 1'b0, 1'b1);
    send_sample(32'd330, 1'b1, 1'b1);
  endtask

  task automatic test_default_random();
    run_button_traffic(300, 60, 30);
  endtask

  task automatic test_fast_extremes();
    set_config(0, 1, 1, 255);
    run_button_traffic(200, 4, 12);
  endtask

  task automatic test_slow_extremes();
    set_config(65535, 65535, 65535, 1);
    run_button_traffic(200, 40000, 6);
  endtask

  task automatic test_zero_settings();
    set_config(0, 0, 0, 0);
    run_button_traffic(150, 10, 10);
  endtask

  task automatic test_random_settings();
    for (int k = 0; k < 4; k++) begin
      set_config($urandom_range(0, 300), $urandom_range(0, 500), $urandom_range(0, 60),
                 int'({8'($urandom), 8'($urandom)}));
      run_button_traffic(80, 50, 40 + 20 * k);
    end
  endtask

  task automatic test_quiet_tail();
    set_config(150, 250, 7, 9);
    tail_part = 1'b1;
    idling_on = 1'b0;
    run_button_traffic(150, 40, 25);
  endtask

  initial begin
    m_cfg     = '{lmc_pkg::DEBOUNCE_RST, lmc_pkg::BLINK_IV_RST, lmc_pkg::FADE_IV_RST,
                  lmc_pkg::FADE_STEP_RST};
    m_mode    = lmc_pkg::MODE_OFF;
    m_press_t = '0;
    m_step_t  = '0;
    m_prev_mb = 1'b1;
    m_prev_rb = 1'b1;
    m_level   = '0;
    m_rising  = 1'b1;
    m_led_a   = 1'b0;
    m_led_b   = 1'b0;
    m_ind     = 1'b0;
    mismatch_count = 0;
    idling_on  = 1'b1;
    tail_part  = 1'b0;
    clock_ms   = '0;
    mode_hold  = 0;
    reset_hold = 0;

    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.now_ms       = '0;
    in_ch.mode_button  = 1'b1;
    in_ch.reset_button = 1'b1;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = lmc_pkg::CFG_DEBOUNCE;
    cfg_ch.data        = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_mode_cycle();
    test_buttons_together();
    test_debounce_edge();
    test_time_wrap();
    test_default_random();
    test_fast_extremes();
    test_slow_extremes();
    test_zero_settings();
    test_random_settings();
    test_quiet_tail();

    wait_results_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== led_mode_cycler_with_fade.f =====
src/lmc_pkg.sv
src/lmc_if.sv
src/lmc_cfg.sv
src/lmc_engine.sv
src/led_mode_cycler_with_fade.sv
bench/tb_top.sv
